// File: hdl/ppt_pkg.sv
// Shared types, codes and constants for the partial permutation table.
package ppt_pkg;

	// Fixed field widths
	localparam int MODE_W  = 3;
	localparam int INDEX_W = 6;
	localparam int IMAGE_W = 7;
	localparam int COUNT_W = 7;
	localparam int CFG_W   = 7;

	// Default table depths
	localparam int MAX_DOMAIN_DEF = 64;
	localparam int MAX_RANGE_DEF  = 64;

	// Reset value of both size registers
	localparam logic [CFG_W-1:0] SIZE_RESET = 7'd64;

	// Configuration register indexes
	localparam logic REG_DOMAIN_SIZE = 1'b0;
	localparam logic REG_RANGE_SIZE  = 1'b1;

	// Operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_APPEND     = 3'd0,
		MODE_SWAP       = 3'd1,
		MODE_REMOVE     = 3'd2,
		MODE_CLEAR      = 3'd3,
		MODE_FWD_LOOKUP = 3'd4,
		MODE_REV_LOOKUP = 3'd5
	} mode_t;

	// Sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SW_RD,
		ST_SW_W1,
		ST_SW_W2,
		ST_RM_HEAD,
		ST_RM_SHIFT,
		ST_RM_TAIL,
		ST_DONE
	} state_t;

	// Source of the lookup field of a result
	typedef enum logic [1:0] {
		LOOK_NONE,
		LOOK_FWD,
		LOOK_REV
	} look_t;

endpackage

// File: hdl/ppt_if.sv
// Command and response channel interfaces of the partial permutation table.
interface ppt_cmd_if;
	logic                               valid;
	logic                               ready;
	logic [ppt_pkg::MODE_W-1:0]         mode;
	logic [ppt_pkg::INDEX_W-1:0]        index_a;
	logic [ppt_pkg::INDEX_W-1:0]        index_b;
	logic signed [ppt_pkg::IMAGE_W-1:0] image_value;

	modport source (output valid, mode, index_a, index_b, image_value, input ready);
	modport sink (input valid, mode, index_a, index_b, image_value, output ready);
endinterface

interface ppt_rsp_if;
	logic                               valid;
	logic                               ready;
	logic signed [ppt_pkg::IMAGE_W-1:0] lookup_value;
	logic [ppt_pkg::COUNT_W-1:0]        defined_count;
	logic                               is_full;
	logic                               error;

	modport source (output valid, lookup_value, defined_count, is_full, error, input ready);
	modport sink (input valid, lookup_value, defined_count, is_full, error, output ready);
endinterface

// File: hdl/partial_permutation_table_core.sv
// Partial permutation table: forward/reverse tables with a sequencer over one table port each.
//
// Usage:
//   cmd (valid/ready) carries one operation per beat: append, swap, remove and
//   add back, clear, forward lookup or reverse lookup. rsp (valid/ready) returns
//   exactly one beat per command with the lookup value (-1 if none), the defined
//   count, the full flag and the refused-append flag.
//   cfg_we/cfg_index/cfg_data write domain_size (index 0) and range_size
//   (index 1); write them only while no command is in flight.
// Sequencing:
//   cmd.ready is high only in idle. Append, clear, lookups and ignored commands
//   go from EXEC to DONE; swap passes through SW_RD, SW_W1 and SW_W2; remove
//   passes through RM_HEAD, a walk in RM_SHIFT over the shifted entries and
//   RM_TAIL. The next command is taken only after DONE has loaded the response
//   register, so the remove walk sets the worst-case period.
// Reset:
//   arst_n clears the valid bits of both tables (entries read as -1), the count
//   and the sequencer; both sizes return to 64. No clearing pass is needed.
// Stall:
//   the response sits in an output register; a new command is accepted while
//   it waits, and the sequencer holds in its last step until the register frees.
module partial_permutation_table_core #(
	parameter int MAX_DOMAIN = ppt_pkg::MAX_DOMAIN_DEF,
	parameter int MAX_RANGE  = ppt_pkg::MAX_RANGE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic                      cfg_index,
	input  logic [ppt_pkg::CFG_W-1:0] cfg_data,
	ppt_cmd_if.sink                   cmd,
	ppt_rsp_if.source                 rsp
);

	localparam int IW  = $clog2(MAX_DOMAIN);
	localparam int RIW = $clog2(MAX_RANGE);
	localparam int CW  = IW + 1;
	localparam int DW  = (CW > ppt_pkg::CFG_W) ? CW : ppt_pkg::CFG_W;
	localparam int RDW = (RIW + 1 > ppt_pkg::CFG_W) ? RIW + 1 : ppt_pkg::CFG_W;
	localparam int RVW = (CW > ppt_pkg::IMAGE_W) ? CW : ppt_pkg::IMAGE_W;
	localparam int VW  = ppt_pkg::IMAGE_W;

	// Configuration registers
	logic [ppt_pkg::CFG_W-1:0] domain_size_q;
	logic [ppt_pkg::CFG_W-1:0] range_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			domain_size_q <= ppt_pkg::SIZE_RESET;
			range_size_q  <= ppt_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ppt_pkg::REG_DOMAIN_SIZE: domain_size_q <= cfg_data;
				ppt_pkg::REG_RANGE_SIZE:  range_size_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective sizes, clamped to 1..MAX
	logic [DW-1:0]  dom;
	logic [RDW-1:0] rng;

	always_comb begin
		if (domain_size_q == '0)
			dom = DW'(1);
		else if (DW'(domain_size_q) > DW'(MAX_DOMAIN))
			dom = DW'(MAX_DOMAIN);
		else
			dom = DW'(domain_size_q);
		if (range_size_q == '0)
			rng = RDW'(1);
		else if (RDW'(range_size_q) > RDW'(MAX_RANGE))
			rng = RDW'(MAX_RANGE);
		else
			rng = RDW'(range_size_q);
	end

	// Command registers
	ppt_pkg::state_t             state_q, state_d;
	ppt_pkg::mode_t              mode_q;
	logic [ppt_pkg::INDEX_W-1:0] ia_q;
	logic [ppt_pkg::INDEX_W-1:0] ib_q;
	logic [VW-1:0]               img_q;

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			mode_q <= ppt_pkg::mode_t'(cmd.mode);
			ia_q   <= cmd.index_a;
			ib_q   <= cmd.index_b;
			img_q  <= cmd.image_value;
		end
	end

	assign cmd.ready = (state_q == ppt_pkg::ST_IDLE);

	// Tables: one write and one registered read per cycle each
	logic [VW-1:0]        fwd_mem [MAX_DOMAIN];
	logic [RVW-1:0]       rev_mem [MAX_RANGE];
	logic [MAX_DOMAIN-1:0] fwd_vld_q;
	logic [MAX_RANGE-1:0]  rev_vld_q;
	logic [VW-1:0]        fwd_rd_q;
	logic                 fwd_rdv_q;
	logic [RVW-1:0]       rev_rd_q;
	logic                 rev_rdv_q;

	logic           fwd_re, fwd_we, rev_re, rev_we, clear_tbl;
	logic [IW-1:0]  fwd_ra, fwd_wa;
	logic [RIW-1:0] rev_ra, rev_wa;
	logic [VW-1:0]  fwd_wd;
	logic [RVW-1:0] rev_wd;

	always_ff @(posedge clk) begin
		if (fwd_we)
			fwd_mem[fwd_wa] <= fwd_wd;
		if (fwd_re) begin
			fwd_rd_q  <= fwd_mem[fwd_ra];
			fwd_rdv_q <= fwd_vld_q[fwd_ra];
		end
		if (rev_we)
			rev_mem[rev_wa] <= rev_wd;
		if (rev_re) begin
			rev_rd_q  <= rev_mem[rev_ra];
			rev_rdv_q <= rev_vld_q[rev_ra];
		end
	end

	// Valid bits: an entry never written since clear reads as -1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= '0;
			rev_vld_q <= '0;
		end else if (clear_tbl) begin
			fwd_vld_q <= '0;
			rev_vld_q <= '0;
		end else begin
			if (fwd_we)
				fwd_vld_q[fwd_wa] <= 1'b1;
			if (rev_we)
				rev_vld_q[rev_wa] <= 1'b1;
		end
	end

	logic [VW-1:0]  fwd_val;
	logic [RVW-1:0] rev_val;

	assign fwd_val = fwd_rdv_q ? fwd_rd_q : '1;
	assign rev_val = rev_rdv_q ? rev_rd_q : '1;

	// Sequencer datapath registers
	logic [CW-1:0]    total_q;
	logic [IW-1:0]    rm_idx_q;
	logic [VW-1:0]    v1_q;
	ppt_pkg::look_t   look_q;
	logic             err_q;
	logic             out_valid_q;
	logic [VW-1:0]    lookup_q;
	logic [ppt_pkg::COUNT_W-1:0] count_q;
	logic             full_q;
	logic             error_q;

	logic           cnt_inc, cnt_clr, idx_ld, idx_inc, v1_ld, look_ld, err_ld, out_ld;
	ppt_pkg::look_t look_d;
	logic           err_d;

	// Operand checks
	logic          ia_ok, ib_ok, img_ok;
	logic [VW-1:0] nv;
	logic [DW-1:0] idx_next1, idx_next2;

	assign ia_ok     = DW'(ia_q) < dom;
	assign ib_ok     = DW'(ib_q) < dom;
	assign img_ok    = !img_q[VW-1] && (RDW'(img_q[VW-2:0]) < rng);
	assign nv        = img_ok ? img_q : '1;
	assign idx_next1 = DW'(rm_idx_q) + DW'(1);
	assign idx_next2 = DW'(rm_idx_q) + DW'(2);

	// Next state and table controls
	always_comb begin
		state_d   = state_q;
		fwd_re    = 1'b0;
		fwd_ra    = IW'(ia_q);
		fwd_we    = 1'b0;
		fwd_wa    = rm_idx_q;
		fwd_wd    = fwd_val;
		rev_re    = 1'b0;
		rev_ra    = RIW'(img_q[VW-2:0]);
		rev_we    = 1'b0;
		rev_wa    = RIW'(fwd_val[VW-2:0]);
		rev_wd    = RVW'(rm_idx_q);
		clear_tbl = 1'b0;
		cnt_inc   = 1'b0;
		cnt_clr   = 1'b0;
		idx_ld    = 1'b0;
		idx_inc   = 1'b0;
		v1_ld     = 1'b0;
		look_ld   = 1'b0;
		look_d    = ppt_pkg::LOOK_NONE;
		err_ld    = 1'b0;
		err_d     = 1'b0;
		out_ld    = 1'b0;
		case (state_q)
			ppt_pkg::ST_IDLE: begin
				if (cmd.valid)
					state_d = ppt_pkg::ST_EXEC;
			end
			ppt_pkg::ST_EXEC: begin
				look_ld = 1'b1;
				err_ld  = 1'b1;
				state_d = ppt_pkg::ST_DONE;
				case (mode_q)
					ppt_pkg::MODE_APPEND: begin
						if (DW'(total_q) >= dom) begin
							err_d = 1'b1;
						end else if (img_ok) begin
							fwd_we  = 1'b1;
							fwd_wa  = total_q[IW-1:0];
							fwd_wd  = img_q;
							rev_we  = 1'b1;
							rev_wa  = RIW'(img_q[VW-2:0]);
							rev_wd  = RVW'(total_q);
							cnt_inc = 1'b1;
						end
					end
					ppt_pkg::MODE_SWAP: begin
						if (ia_ok && ib_ok) begin
							fwd_re  = 1'b1;
							fwd_ra  = IW'(ia_q);
							state_d = ppt_pkg::ST_SW_RD;
						end
					end
					ppt_pkg::MODE_REMOVE: begin
						if (ia_ok) begin
							fwd_re  = 1'b1;
							fwd_ra  = IW'(ia_q);
							idx_ld  = 1'b1;
							state_d = ppt_pkg::ST_RM_HEAD;
						end
					end
					ppt_pkg::MODE_CLEAR: begin
						clear_tbl = 1'b1;
						cnt_clr   = 1'b1;
					end
					ppt_pkg::MODE_FWD_LOOKUP: begin
						if (ia_ok) begin
							fwd_re = 1'b1;
							fwd_ra = IW'(ia_q);
							look_d = ppt_pkg::LOOK_FWD;
						end
					end
					ppt_pkg::MODE_REV_LOOKUP: begin
						if (img_ok) begin
							rev_re = 1'b1;
							rev_ra = RIW'(img_q[VW-2:0]);
							look_d = ppt_pkg::LOOK_REV;
						end
					end
					default: ;
				endcase
			end
			// Swap: read second image while holding the first
			ppt_pkg::ST_SW_RD: begin
				v1_ld   = 1'b1;
				fwd_re  = 1'b1;
				fwd_ra  = IW'(ib_q);
				state_d = ppt_pkg::ST_SW_W1;
			end
			ppt_pkg::ST_SW_W1: begin
				fwd_we  = 1'b1;
				fwd_wa  = IW'(ib_q);
				fwd_wd  = v1_q;
				rev_we  = !v1_q[VW-1];
				rev_wa  = RIW'(v1_q[VW-2:0]);
				rev_wd  = RVW'(ib_q);
				state_d = ppt_pkg::ST_SW_W2;
			end
			ppt_pkg::ST_SW_W2: begin
				fwd_we  = 1'b1;
				fwd_wa  = IW'(ia_q);
				fwd_wd  = fwd_val;
				rev_we  = !fwd_val[VW-1];
				rev_wa  = RIW'(fwd_val[VW-2:0]);
				rev_wd  = RVW'(ia_q);
				state_d = ppt_pkg::ST_DONE;
			end
			// Remove: drop the old image's reverse entry, then start the walk
			ppt_pkg::ST_RM_HEAD: begin
				rev_we = !fwd_val[VW-1];
				rev_wa = RIW'(fwd_val[VW-2:0]);
				rev_wd = '1;
				if (idx_next1 < dom) begin
					fwd_re  = 1'b1;
					fwd_ra  = IW'(idx_next1);
					state_d = ppt_pkg::ST_RM_SHIFT;
				end else begin
					state_d = ppt_pkg::ST_RM_TAIL;
				end
			end
			// Shift one defined entry down per cycle, prefetching the next
			ppt_pkg::ST_RM_SHIFT: begin
				if (fwd_val[VW-1]) begin
					state_d = ppt_pkg::ST_RM_TAIL;
				end else begin
					fwd_we  = 1'b1;
					fwd_wa  = rm_idx_q;
					fwd_wd  = fwd_val;
					rev_we  = 1'b1;
					rev_wa  = RIW'(fwd_val[VW-2:0]);
					rev_wd  = RVW'(rm_idx_q);
					idx_inc = 1'b1;
					if (idx_next2 < dom) begin
						fwd_re = 1'b1;
						fwd_ra = IW'(idx_next2);
					end else begin
						state_d = ppt_pkg::ST_RM_TAIL;
					end
				end
			end
			ppt_pkg::ST_RM_TAIL: begin
				fwd_we  = 1'b1;
				fwd_wa  = rm_idx_q;
				fwd_wd  = nv;
				rev_we  = !nv[VW-1];
				rev_wa  = RIW'(nv[VW-2:0]);
				rev_wd  = RVW'(rm_idx_q);
				state_d = ppt_pkg::ST_DONE;
			end
			// Hand the result to the output register once it is free
			ppt_pkg::ST_DONE: begin
				if (!out_valid_q || rsp.ready) begin
					out_ld  = 1'b1;
					state_d = ppt_pkg::ST_IDLE;
				end
			end
			default: state_d = ppt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ppt_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// Defined count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			total_q <= '0;
		else if (cnt_clr)
			total_q <= '0;
		else if (cnt_inc)
			total_q <= total_q + CW'(1);
	end

	// Walk index, held first image, lookup source and error flag
	always_ff @(posedge clk) begin
		if (idx_ld)
			rm_idx_q <= IW'(ia_q);
		else if (idx_inc)
			rm_idx_q <= rm_idx_q + IW'(1);
		if (v1_ld)
			v1_q <= fwd_val;
		if (look_ld)
			look_q <= look_d;
		if (err_ld)
			err_q <= err_d;
	end

	// Response register
	logic [VW-1:0] lookup_d;

	always_comb begin
		case (look_q)
			ppt_pkg::LOOK_FWD: lookup_d = fwd_val;
			ppt_pkg::LOOK_REV: lookup_d = rev_val[VW-1:0];
			default:           lookup_d = '1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_ld)
			out_valid_q <= 1'b1;
		else if (rsp.ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			lookup_q <= lookup_d;
			count_q  <= ppt_pkg::COUNT_W'(total_q);
			full_q   <= (DW'(total_q) == dom);
			error_q  <= err_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.lookup_value  = lookup_q;
	assign rsp.defined_count = count_q;
	assign rsp.is_full       = full_q;
	assign rsp.error         = error_q;

	// Count never exceeds the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		DW'(total_q) <= DW'(MAX_DOMAIN))
		else $error("defined count beyond table depth");

	// A clear empties the count on the next edge
	a_clear_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppt_pkg::ST_EXEC && mode_q == ppt_pkg::MODE_CLEAR) |=> (total_q == '0))
		else $error("count not zero after clear");

	// Clearing the valid bits never coincides with a table write
	a_clear_excl: assert property (@(posedge clk) disable iff (!arst_n)
		clear_tbl |-> (!fwd_we && !rev_we))
		else $error("table write during clear");

	// The remove walk always has a next entry inside the domain
	a_walk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ppt_pkg::ST_RM_SHIFT) |-> (idx_next1 < dom))
		else $error("remove walk beyond domain size");

endmodule

// File: tb/partial_permutation_table_core_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the partial permutation table core.
module partial_permutation_table_core_tb;

	localparam int MODE_W = ppt_pkg::MODE_W;
	localparam int INDEX_W = ppt_pkg::INDEX_W;
	localparam int IMAGE_W = ppt_pkg::IMAGE_W;
	localparam int COUNT_W = ppt_pkg::COUNT_W;
	localparam int CFG_W = ppt_pkg::CFG_W;
	localparam int DOM_DEPTH = ppt_pkg::MAX_DOMAIN_DEF;
	localparam int RNG_DEPTH = ppt_pkg::MAX_RANGE_DEF;
	localparam int N_DIR = 24;
	localparam int N_PHASES = 8;
	localparam int OPS_PER_PHASE = 220;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 80;
	localparam int MAX_REPORTS = 10;

	// Mode codes the block does not define
	localparam int MODE_SPARE_6 = 6;
	localparam int MODE_SPARE_7 = 7;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic [INDEX_W-1:0]        ia;
		logic [INDEX_W-1:0]        ib;
		logic signed [IMAGE_W-1:0] img;
	} op_beat_t;

	typedef struct packed {
		logic signed [IMAGE_W-1:0] look;
		logic [COUNT_W-1:0]        count;
		logic                      full;
		logic                      err;
	} status_beat_t;

	// Directed row: command, flag for a typed-in answer, typed-in answer
	typedef struct {
		int mode;
		int ia;
		int ib;
		int img;
		int fixed;
		int look;
		int count;
		int full;
		int err;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_W-1:0] cfg_data;

	ppt_cmd_if cmd_ch ();
	ppt_rsp_if rsp_ch ();

	partial_permutation_table_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow copy of the tables, the count and the size registers
	int fwd_map [DOM_DEPTH];
	int rev_map [RNG_DEPTH];
	int n_defined;
	logic [CFG_W-1:0] dom_reg;
	logic [CFG_W-1:0] rng_reg;

	status_beat_t status_q [$];
	int pending;
	int fail_count;
	int quiet_cycles;
	int cmd_idle_pct;
	int rsp_stall_pct;
	bit hold_req;
	int hold_n;
	status_beat_t got_beat;
	status_beat_t want_beat;

	// Directed sequence, run with domain size 4 and range size 8
	dir_row_t dir_tbl [N_DIR] = '{
		'{ppt_pkg::MODE_FWD_LOOKUP, 0, 0, -1, 1, -1, 0, 0, 0},
		'{ppt_pkg::MODE_REV_LOOKUP, 0, 0, -1, 1, -1, 0, 0, 0},
		'{ppt_pkg::MODE_APPEND, 0, 0, 5, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_APPEND, 0, 0, 63, 1, -1, 1, 0, 0},
		'{ppt_pkg::MODE_APPEND, 0, 0, 5, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_APPEND, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_APPEND, 0, 0, 7, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_APPEND, 0, 0, 2, 1, -1, 4, 1, 1},
		'{ppt_pkg::MODE_SWAP, 0, 3, 0, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_SWAP, 63, 0, 0, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_FWD_LOOKUP, 63, 0, 0, 1, -1, 4, 1, 0},
		'{ppt_pkg::MODE_REV_LOOKUP, 0, 0, 5, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_REMOVE, 1, 0, 3, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_REMOVE, 0, 0, -1, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_REMOVE, 3, 0, 63, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_SWAP, 2, 3, 0, 0, 0, 0, 0, 0},
		'{MODE_SPARE_6, 63, 63, 63, 0, 0, 0, 0, 0},
		'{MODE_SPARE_7, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_REV_LOOKUP, 0, 0, -64, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_CLEAR, 0, 0, 0, 1, -1, 0, 0, 0},
		'{ppt_pkg::MODE_REMOVE, 0, 0, 1, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_FWD_LOOKUP, 0, 0, 0, 0, 0, 0, 0, 0},
		'{ppt_pkg::MODE_FWD_LOOKUP, 3, 0, 0, 1, -1, 0, 0, 0},
		'{ppt_pkg::MODE_APPEND, 0, 0, -64, 0, 0, 0, 0, 0}
	};

	// Size settings per random phase; 0 and 127 saturate to 1 and 64
	int phase_dom [N_PHASES] = '{64, 1, 0, 127, 6, 64, 20, 40};
	int phase_rng [N_PHASES] = '{64, 1, 0, 127, 4, 12, 64, 40};

	function automatic int eff_size(input logic [CFG_W-1:0] v, input int max_v);
		if (v == 0)
			return 1;
		if (int'(v) > max_v)
			return max_v;
		return int'(v);
	endfunction

	function automatic void wipe_tables();
		for (int i = 0; i < DOM_DEPTH; i++)
			fwd_map[i] = -1;
		for (int i = 0; i < RNG_DEPTH; i++)
			rev_map[i] = -1;
		n_defined = 0;
	endfunction

	// Apply one operation to the shadow tables and return the status beat it yields
	function automatic status_beat_t apply_op(input op_beat_t c);
		int dom, rng, img, ia, ib, v1, v2, nv, i;
		bit img_ok;
		status_beat_t r;
		dom = eff_size(dom_reg, DOM_DEPTH);
		rng = eff_size(rng_reg, RNG_DEPTH);
		img = int'(c.img);
		ia = int'(c.ia);
		ib = int'(c.ib);
		img_ok = (img >= 0) && (img < rng);
		r.look = IMAGE_W'(-1);
		r.err = 1'b0;
		case (c.mode)
			ppt_pkg::MODE_APPEND: begin
				if (n_defined >= dom) begin
					r.err = 1'b1;
				end else if (img_ok) begin
					fwd_map[n_defined] = img;
					rev_map[img] = n_defined;
					n_defined++;
				end
			end
			ppt_pkg::MODE_SWAP: begin
				if (ia < dom && ib < dom) begin
					v1 = fwd_map[ia];
					v2 = fwd_map[ib];
					fwd_map[ib] = v1;
					fwd_map[ia] = v2;
					// undefined images leave the reverse table alone
					if (v1 >= 0)
						rev_map[v1] = ib;
					if (v2 >= 0)
						rev_map[v2] = ia;
				end
			end
			ppt_pkg::MODE_REMOVE: begin
				if (ia < dom) begin
					nv = img_ok ? img : -1;
					if (fwd_map[ia] >= 0)
						rev_map[fwd_map[ia]] = -1;
					// shift later defined entries down until the first hole
					i = ia;
					while (i + 1 < dom && fwd_map[i + 1] >= 0) begin
						rev_map[fwd_map[i + 1]] = i;
						fwd_map[i] = fwd_map[i + 1];
						i++;
					end
					fwd_map[i] = nv;
					if (nv >= 0)
						rev_map[nv] = i;
				end
			end
			ppt_pkg::MODE_CLEAR: wipe_tables();
			ppt_pkg::MODE_FWD_LOOKUP: begin
				if (ia < dom)
					r.look = IMAGE_W'(fwd_map[ia]);
			end
			ppt_pkg::MODE_REV_LOOKUP: begin
				if (img_ok)
					r.look = IMAGE_W'(rev_map[img]);
			end
			default: ;
		endcase
		r.count = COUNT_W'(n_defined);
		r.full = (n_defined == dom);
		return r;
	endfunction

	// Random operation, mostly legal indices and images for the current sizes
	function automatic op_beat_t rand_op();
		int dom, rng, pick;
		op_beat_t c;
		dom = eff_size(dom_reg, DOM_DEPTH);
		rng = eff_size(rng_reg, RNG_DEPTH);
		pick = $urandom_range(0, 99);
		if (pick < 32)
			c.mode = ppt_pkg::MODE_APPEND;
		else if (pick < 46)
			c.mode = ppt_pkg::MODE_SWAP;
		else if (pick < 64)
			c.mode = ppt_pkg::MODE_REMOVE;
		else if (pick < 65)
			c.mode = ppt_pkg::MODE_CLEAR;
		else if (pick < 80)
			c.mode = ppt_pkg::MODE_FWD_LOOKUP;
		else if (pick < 95)
			c.mode = ppt_pkg::MODE_REV_LOOKUP;
		else
			c.mode = MODE_W'($urandom_range(0, 7));
		if ($urandom_range(0, 9) == 0)
			c.ia = INDEX_W'($urandom_range(0, 63));
		else
			c.ia = INDEX_W'($urandom_range(0, dom - 1));
		if ($urandom_range(0, 9) == 0)
			c.ib = INDEX_W'($urandom_range(0, 63));
		else
			c.ib = INDEX_W'($urandom_range(0, dom - 1));
		pick = $urandom_range(0, 9);
		if (pick == 0)
			c.img = IMAGE_W'(-1);
		else if (pick == 1)
			c.img = IMAGE_W'($urandom);
		else
			c.img = IMAGE_W'($urandom_range(0, rng - 1));
		return c;
	endfunction

	// Offer one command beat; predict once it is accepted
	task automatic send_op(input op_beat_t c, input bit fixed, input status_beat_t fixed_rsp);
		status_beat_t want;
		@(negedge clk);
		while ($urandom_range(0, 99) < cmd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.mode <= c.mode;
		cmd_ch.index_a <= c.ia;
		cmd_ch.index_b <= c.ib;
		cmd_ch.image_value <= c.img;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		want = apply_op(c);
		if (fixed)
			want = fixed_rsp;
		status_q.push_back(want);
		pending++;
	endtask

	// Stop offering and wait for every outstanding status beat
	task automatic drain();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		wait (pending == 0);
	endtask

	// Write both size registers back to back
	task automatic set_sizes(input logic [CFG_W-1:0] dom, input logic [CFG_W-1:0] rng);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ppt_pkg::REG_DOMAIN_SIZE;
		cfg_data <= dom;
		@(negedge clk);
		cfg_index <= ppt_pkg::REG_RANGE_SIZE;
		cfg_data <= rng;
		@(negedge clk);
		cfg_we <= 1'b0;
		dom_reg = dom;
		rng_reg = rng;
	endtask

	// Response ready: random stalls, plus one long hold-off on request
	initial begin
		rsp_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				for (hold_n = 0; hold_n < HOLD_CYCLES; hold_n++) begin
					rsp_ch.ready <= 1'b0;
					@(negedge clk);
				end
			end
			rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
		end
	end

	// Response checker and stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got_beat.look = rsp_ch.lookup_value;
				got_beat.count = rsp_ch.defined_count;
				got_beat.full = rsp_ch.is_full;
				got_beat.err = rsp_ch.error;
				if (status_q.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$display("%0t: status beat with none expected: look %0d count %0d full %0b err %0b",
							$realtime, got_beat.look, got_beat.count, got_beat.full, got_beat.err);
				end else begin
					want_beat = status_q.pop_front();
					pending--;
					if (got_beat !== want_beat) begin
						fail_count++;
						if (fail_count <= MAX_REPORTS)
							$display("%0t: mismatch look %0d/%0d count %0d/%0d full %0b/%0b err %0b/%0b (exp/got)",
								$realtime, want_beat.look, got_beat.look, want_beat.count,
								got_beat.count, want_beat.full, got_beat.full, want_beat.err,
								got_beat.err);
					end
				end
			end
		end
	end

	// Main sequence
	initial begin
		op_beat_t op;
		status_beat_t fixed_rsp;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = ppt_pkg::REG_DOMAIN_SIZE;
		cfg_data = '0;
		cmd_ch.valid = 1'b0;
		cmd_ch.mode = ppt_pkg::MODE_APPEND;
		cmd_ch.index_a = '0;
		cmd_ch.index_b = '0;
		cmd_ch.image_value = '0;
		pending = 0;
		fail_count = 0;
		quiet_cycles = 0;
		cmd_idle_pct = 0;
		rsp_stall_pct = 0;
		hold_req = 1'b0;
		wipe_tables();
		dom_reg = ppt_pkg::SIZE_RESET;
		rng_reg = ppt_pkg::SIZE_RESET;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part on a small table
		set_sizes(7'd4, 7'd8);
		for (int k = 0; k < N_DIR; k++) begin
			op.mode = MODE_W'(dir_tbl[k].mode);
			op.ia = INDEX_W'(dir_tbl[k].ia);
			op.ib = INDEX_W'(dir_tbl[k].ib);
			op.img = IMAGE_W'(dir_tbl[k].img);
			fixed_rsp.look = IMAGE_W'(dir_tbl[k].look);
			fixed_rsp.count = COUNT_W'(dir_tbl[k].count);
			fixed_rsp.full = (dir_tbl[k].full != 0);
			fixed_rsp.err = (dir_tbl[k].err != 0);
			send_op(op, dir_tbl[k].fixed != 0, fixed_rsp);
		end
		drain();

		// Random phases, each with its own sizes; the idle pattern repeats every four phases
		for (int p = 0; p < N_PHASES; p++) begin
			set_sizes(CFG_W'(phase_dom[p]), CFG_W'(phase_rng[p]));
			case (p % 4)
				0: begin
					cmd_idle_pct = 0;
					rsp_stall_pct = 0;
				end
				1: begin
					cmd_idle_pct = 86;
					rsp_stall_pct = 0;
				end
				2: begin
					cmd_idle_pct = 0;
					rsp_stall_pct = 86;
				end
				default: begin
					cmd_idle_pct = 36;
					rsp_stall_pct = 36;
				end
			endcase
			// first phase: long response hold-off so the command side backs up
			if (p == 0)
				hold_req = 1'b1;
			for (int n = 0; n < OPS_PER_PHASE; n++)
				send_op(rand_op(), 1'b0, '0);
			drain();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && status_q.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
